### src/pip_pkg.sv
// Shared constants and types for the point-in-polygon test block.
`default_nettype none
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  localparam int QDEPTH       = 4;
  localparam int QADDR_W      = $clog2(QDEPTH);
  localparam int QCNT_W       = $clog2(QDEPTH + 1);

  localparam logic OP_APPEND  = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic                  op;
    logic                  new_polygon;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
  } item_t;

endpackage
`default_nettype wire

### src/pip_front.sv
// Front end: registers incoming beats and decodes them into queue items.
`default_nettype none
module pip_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [2*pip_pkg::COORD_BITS-1:0] s_axis_tdata,
  input  wire logic [1:0]                      s_axis_tuser,
  output logic                                 item_valid,
  input  wire logic                            item_ready,
  output pip_pkg::item_t                       item
);
  import pip_pkg::*;

  logic  vld;
  item_t hold;
  logic  take;

  assign s_axis_tready = !vld || item_ready;
  assign take          = s_axis_tvalid && s_axis_tready;
  assign item_valid    = vld;
  assign item          = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (take) begin
      vld <= 1'b1;
    end else if (item_ready) begin
      vld <= 1'b0;
    end
  end

  // A new_polygon flag only has meaning on an append, so queries drop it here.
  always_ff @(posedge clk) begin
    if (take) begin
      hold.op          <= s_axis_tuser[0] ? OP_QUERY : OP_APPEND;
      hold.new_polygon <= s_axis_tuser[1] && !s_axis_tuser[0];
      hold.coord_x     <= s_axis_tdata[COORD_BITS-1:0];
      hold.coord_y     <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    end
  end

endmodule
`default_nettype wire

### src/pip_queue.sv
// Short item queue between the front end and the back end.
`default_nettype none
module pip_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pip_pkg::item_t in_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pip_pkg::item_t      out_item
);
  import pip_pkg::*;

  item_t              slots [QDEPTH];
  logic [QADDR_W-1:0] wr_ptr;
  logic [QADDR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0]  fill;
  logic               push;
  logic               pop;

  assign in_ready  = fill != QCNT_W'(QDEPTH);
  assign out_valid = fill != '0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QADDR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QADDR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule
`default_nettype wire

### src/pip_back.sv
// Back end: vertex store, edge walk with crossing test, and result register.
`default_nettype none
module pip_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           item_valid,
  output logic                item_ready,
  input  wire pip_pkg::item_t item,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [7:0]          m_axis_tdata
);
  import pip_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  logic [1:0]       state, state_next;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] k, k_next;
  logic             parity, parity_next;
  logic signed [COORD_BITS-1:0] px, py;

  logic             out_valid, out_inside, out_status;
  logic             out_load, out_free;
  logic             load_inside, load_status;

  logic             wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0] eff_count;
  logic             rd_en;
  logic [CNT_W-1:0] rd_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic             start_walk;

  logic signed [COORD_BITS-1:0] rdx, rdy;
  logic signed [COORD_BITS-1:0] xj, yj;
  logic             rd_vld, rd_first, rd_last;

  logic signed [DIFF_W-1:0] xi_e, yi_e, xj_e, yj_e, px_e, py_e;
  logic signed [DIFF_W-1:0] dy, dpy, d1, d2, mag_a, mag_b;
  logic             straddle;

  logic             s1_vld, s1_last, s1_str;
  logic signed [PROD_W-1:0] p1, p2;
  logic             left_of;

  assign out_free      = !out_valid || m_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_status, out_inside};

  assign eff_count = item.new_polygon ? '0 : count;
  assign rd_idx    = (k == '0) ? count - 1'b1 : k - 1'b1;
  assign rd_addr   = rd_idx[ADDR_W-1:0];
  assign wr_addr   = eff_count[ADDR_W-1:0];

  always_comb begin
    state_next  = state;
    count_next  = count;
    k_next      = k;
    parity_next = parity;
    item_ready  = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    load_inside = 1'b0;
    load_status = STATUS_OK;
    start_walk  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (item_valid && out_free) begin
          item_ready = 1'b1;
          if (item.op == OP_APPEND) begin
            out_load = 1'b1;
            if (eff_count == CNT_W'(MAX_VERTICES)) begin
              load_status = STATUS_FULL;
              count_next  = eff_count;
            end else begin
              wr_en      = 1'b1;
              count_next = eff_count + 1'b1;
            end
          end else if (count == '0) begin
            out_load = 1'b1;
          end else begin
            start_walk  = 1'b1;
            k_next      = '0;
            parity_next = 1'b0;
            state_next  = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // Reads go out as last vertex, then vertex 0 up to the last again.
        rd_en  = 1'b1;
        k_next = k + 1'b1;
        if (k == count) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (s1_vld) begin
          parity_next = parity ^ (s1_str && left_of);
          if (s1_last) begin
            out_load    = 1'b1;
            load_inside = parity_next;
            state_next  = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (state == ST_WALK && s1_vld) begin
      parity_next = parity ^ (s1_str && left_of);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      rd_vld    <= 1'b0;
      s1_vld    <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_vld <= rd_en;
      s1_vld <= rd_vld && !rd_first;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    k      <= k_next;
    parity <= parity_next;
    if (start_walk) begin
      px <= item.coord_x;
      py <= item.coord_y;
    end
    if (out_load) begin
      out_inside <= load_inside;
      out_status <= load_status;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr] <= item.coord_x;
      mem_y[wr_addr] <= item.coord_y;
    end
    if (rd_en) begin
      rdx <= mem_x[rd_addr];
      rdy <= mem_y[rd_addr];
    end
    rd_first <= (k == '0);
    rd_last  <= (k == count);
  end

  // The vertex read last cycle becomes the trailing end of the next edge.
  assign xi_e = DIFF_W'(rdx);
  assign yi_e = DIFF_W'(rdy);
  assign xj_e = DIFF_W'(xj);
  assign yj_e = DIFF_W'(yj);
  assign px_e = DIFF_W'(px);
  assign py_e = DIFF_W'(py);

  assign straddle = ((rdy <= py) && (py < yj)) || ((yj <= py) && (py < rdy));
  assign dy    = yj_e - yi_e;
  assign dpy   = py_e - yi_e;
  assign d1    = px_e - xi_e;
  assign d2    = xj_e - xi_e;
  assign mag_a = dy[DIFF_W-1]  ? -dy  : dy;
  assign mag_b = dpy[DIFF_W-1] ? -dpy : dpy;

  // The point is left of the crossing when (px-xi)*|dy| < (xj-xi)*|py-yi|.
  always_ff @(posedge clk) begin
    if (rd_vld) begin
      xj      <= rdx;
      yj      <= rdy;
      s1_str  <= straddle;
      s1_last <= rd_last;
      p1      <= d1 * mag_a;
      p2      <= d2 * mag_b;
    end
  end

  assign left_of = p1 < p2;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond store size");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> (state == ST_IDLE))
    else $error("item taken while an edge walk is running");

  a_walk_quiet: assert property (@(posedge clk) disable iff (rst)
    (s1_vld || rd_vld) |-> (state == ST_WALK || state == ST_WAIT || out_load))
    else $error("edge pipeline active outside a walk");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("result overwrites a beat still waiting");

  a_append_grows: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count == $past(eff_count) + 1'b1))
    else $error("append did not advance the vertex count");

endmodule
`default_nettype wire

### src/point_in_polygon_test.sv
// Top level of the even-odd point-in-polygon test block.
// Append: one append per cycle is taken while the result side accepts beats.
// Query over n stored vertices: the back end walks the edges with one vertex-store read
// per cycle, lets the crossing stage drain, then loads the result and takes the next item.
// A query on an empty store answers without a walk.
// Synchronous reset empties the queue and sets the vertex count to zero.
`default_nettype none
module point_in_polygon_test (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [2*pip_pkg::COORD_BITS-1:0] s_axis_tdata,  // coord_x, coord_y
  input  wire logic [1:0]                      s_axis_tuser,  // cmd, new_polygon
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic [7:0]                           m_axis_tdata   // inside_res, status, zeros
);
  import pip_pkg::*;

  logic  f_valid, f_ready;
  item_t f_item;
  logic  b_valid, b_ready;
  item_t b_item;

  pip_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .item_valid    (f_valid),
    .item_ready    (f_ready),
    .item          (f_item)
  );

  pip_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_item  (b_item)
  );

  pip_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (b_valid),
    .item_ready    (b_ready),
    .item          (b_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule
`default_nettype wire

### tb/pip_checker.sv
// Checker for the point-in-polygon block: predicts every result beat and compares it.
module pip_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_valid,
  input  wire logic                             s_ready,
  input  wire logic [2*pip_pkg::COORD_BITS-1:0] s_data,   // coord_x, coord_y
  input  wire logic [1:0]                       s_user,   // cmd, new_polygon
  input  wire logic                             m_valid,
  input  wire logic                             m_ready,
  input  wire logic [7:0]                       m_data,   // inside_res, status, zeros
  output int                                    fail_count,
  output int                                    outstanding,
  output int                                    inside_count,
  output int                                    drop_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  typedef struct packed {
    logic inside_res;
    logic status;
  } pip_result_t;

  logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  int unsigned                  poly_len;
  pip_result_t                  expected_results [$];

  pip_result_t                  want;
  pip_result_t                  got;
  logic signed [COORD_BITS-1:0] pt_x;
  logic signed [COORD_BITS-1:0] pt_y;
  int                           errors;
  int                           hits;
  int                           drops;

  initial begin
    errors       = 0;
    hits         = 0;
    drops        = 0;
    poly_len     = 0;
  end

  // Even-odd crossing test over the stored polygon. The crossing x is compared
  // by scaling both sides with |dy|, which keeps the test exact.
  function automatic logic crossing_parity(input longint px, input longint py);
    logic        odd;
    int unsigned j;
    longint      xi, yi, xj, yj, dy, dpy, lhs, rhs;
    odd = 1'b0;
    if (poly_len == 0) return 1'b0;
    j = poly_len - 1;
    for (int unsigned i = 0; i < poly_len; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      if (((yi <= py) && (py < yj)) || ((yj <= py) && (py < yi))) begin
        dy  = yj - yi;
        dpy = py - yi;
        if (dy < 0) dy = -dy;
        if (dpy < 0) dpy = -dpy;
        lhs = (px - xi) * dy;
        rhs = (xj - xi) * dpy;
        if (lhs < rhs) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      poly_len = 0;
      expected_results.delete();
    end else begin
      if (s_valid && s_ready) begin
        pt_x = s_data[COORD_BITS-1:0];
        pt_y = s_data[2*COORD_BITS-1:COORD_BITS];
        want = '0;
        if (s_user[0] == OP_APPEND) begin
          if (s_user[1]) poly_len = 0;
          if (poly_len >= MAX_VERTICES) begin
            want.status = STATUS_FULL;
            drops++;
          end else begin
            poly_x[poly_len] = pt_x;
            poly_y[poly_len] = pt_y;
            poly_len++;
            want.status = STATUS_OK;
          end
        end else begin
          want.inside_res = crossing_parity(longint'(pt_x), longint'(pt_y));
          want.status     = STATUS_OK;
          if (want.inside_res) hits++;
        end
        expected_results.insert(expected_results.size(), want);
      end
      if (m_valid && m_ready) begin
        got.inside_res = m_data[0];
        got.status     = m_data[1];
        if (expected_results.size() == 0) begin
          $error("result beat arrived with no result pending (data %0h)", m_data);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.inside_res !== want.inside_res) begin
            $error("inside_res: expected %0d, actual %0d", want.inside_res, got.inside_res);
            errors++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (m_data[7:2] !== 6'd0) begin
            $error("padding: expected 0, actual %0h", m_data[7:2]);
            errors++;
          end
        end
      end
    end
    fail_count   <= errors;
    outstanding  <= expected_results.size();
    inside_count <= hits;
    drop_count   <= drops;
  end

endmodule

### tb/point_in_polygon_test_tb.sv
// Testbench top for the point-in-polygon block: stimulus, back-pressure and verdict.
module point_in_polygon_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  localparam int RANDOM_ITEMS = 1800;
  localparam int SHAPE_SLOTS  = MAX_VERTICES + 4;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [2*COORD_BITS-1:0] s_axis_tdata = '0;   // coord_x, coord_y
  logic [1:0]              s_axis_tuser = '0;   // cmd, new_polygon
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [7:0]              m_axis_tdata;        // inside_res, status, zeros

  int fail_count;
  int outstanding;
  int inside_count;
  int drop_count;
  int sent_appends = 0;
  int sent_queries = 0;
  bit calm = 1'b0;   // while set, neither side inserts idle cycles

  int shape_x [SHAPE_SLOTS];
  int shape_y [SHAPE_SLOTS];

  point_in_polygon_test u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  pip_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_valid      (s_axis_tvalid),
    .s_ready      (s_axis_tready),
    .s_data       (s_axis_tdata),
    .s_user       (s_axis_tuser),
    .m_valid      (m_axis_tvalid),
    .m_ready      (m_axis_tready),
    .m_data       (m_axis_tdata),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .inside_count (inside_count),
    .drop_count   (drop_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic [COORD_BITS-1:0] clamp_coord(input int v);
    if (v < -32768) return 16'h8000;
    if (v > 32767) return 16'h7fff;
    return v[COORD_BITS-1:0];
  endfunction

  // Coordinate styles: full random, a tight cluster (many equal y values),
  // a wider cluster, and the extremes of the signed range.
  function automatic logic [COORD_BITS-1:0] pick_coord(input int style, input int center);
    case (style)
      0: return COORD_BITS'($urandom());
      1: return clamp_coord(center + int'($urandom_range(8)) - 4);
      2: return clamp_coord(center + int'($urandom_range(600)) - 300);
      default: begin
        case ($urandom_range(6))
          0: return 16'h8000;
          1: return 16'h8001;
          2: return 16'hffff;
          3: return 16'h0000;
          4: return 16'h0001;
          5: return 16'h7ffe;
          default: return 16'h7fff;
        endcase
      end
    endcase
  endfunction

  task automatic send_beat(input logic op, input logic newp,
                           input logic [COORD_BITS-1:0] x, input logic [COORD_BITS-1:0] y);
    int gap;
    gap = calm ? 0 : $urandom_range(4);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {newp, op};
    s_axis_tdata  <= {y, x};
    do @(posedge clk); while (!s_axis_tready);
    if (op == OP_APPEND) sent_appends++;
    else sent_queries++;
  endtask

  // Holds the input side off until every pending result has been seen.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: a random stall before each beat, none while calm is set.
  initial begin
    int stall;
    forever begin
      stall = calm ? 0 : $urandom_range(4);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    #3_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int target;
    int kind;
    int n;
    int style;
    int center_x;
    int center_y;
    int q;
    int mode;
    int a;
    int b;
    logic newp;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty store, one vertex, and two vertices.
    send_beat(OP_QUERY, 1'b1, 16'd0, 16'd0);
    send_beat(OP_APPEND, 1'b1, 16'd100, 16'd100);
    send_beat(OP_QUERY, 1'b0, 16'd50, 16'd100);
    send_beat(OP_APPEND, 1'b0, -16'sd100, 16'd200);
    send_beat(OP_QUERY, 1'b0, 16'd0, 16'd150);
    // Triangle spanning the full signed range, with a horizontal bottom edge.
    send_beat(OP_APPEND, 1'b1, 16'h8000, 16'h8000);
    send_beat(OP_APPEND, 1'b0, 16'h7fff, 16'h8000);
    send_beat(OP_APPEND, 1'b0, 16'h0000, 16'h7fff);
    send_beat(OP_QUERY, 1'b0, 16'h0000, 16'h0000);
    send_beat(OP_QUERY, 1'b1, 16'h8000, 16'h8000);
    send_beat(OP_QUERY, 1'b0, 16'h7fff, 16'h7fff);
    send_beat(OP_QUERY, 1'b0, 16'h8000, 16'h0000);
    send_beat(OP_QUERY, 1'b0, 16'h0000, 16'h8000);
    // Square: points on its horizontal and vertical edges and just outside.
    send_beat(OP_APPEND, 1'b1, -16'sd10, -16'sd10);
    send_beat(OP_APPEND, 1'b0, 16'sd10, -16'sd10);
    send_beat(OP_APPEND, 1'b0, 16'sd10, 16'sd10);
    send_beat(OP_APPEND, 1'b0, -16'sd10, 16'sd10);
    send_beat(OP_QUERY, 1'b0, 16'sd0, 16'sd0);
    send_beat(OP_QUERY, 1'b0, 16'sd0, -16'sd10);
    send_beat(OP_QUERY, 1'b0, 16'sd0, 16'sd10);
    send_beat(OP_QUERY, 1'b0, -16'sd10, 16'sd0);
    send_beat(OP_QUERY, 1'b0, 16'sd10, 16'sd0);
    send_beat(OP_QUERY, 1'b0, -16'sd11, 16'sd0);
    send_beat(OP_QUERY, 1'b1, 16'h7fff, 16'h8000);
    wait_drained();

    target = sent_appends + sent_queries + RANDOM_ITEMS;
    while (sent_appends + sent_queries < target) begin
      calm  = ($urandom_range(7) == 0);
      kind  = $urandom_range(99);
      if (kind < 6) n = $urandom_range(2);
      else if (kind < 10) n = $urandom_range(MAX_VERTICES, MAX_VERTICES - 4);
      else if (kind < 13) n = MAX_VERTICES + $urandom_range(3, 1);  // runs past a full store
      else n = $urandom_range(12, 3);
      style    = $urandom_range(3);
      center_x = int'($urandom_range(65535)) - 32768;
      center_y = int'($urandom_range(65535)) - 32768;

      for (int i = 0; i < n; i++) begin
        shape_x[i] = int'($signed(pick_coord(style, center_x)));
        shape_y[i] = int'($signed(pick_coord(style, center_y)));
        if (i == 0) newp = ($urandom_range(9) != 0);
        else newp = ($urandom_range(49) == 0);
        send_beat(OP_APPEND, newp, shape_x[i][COORD_BITS-1:0], shape_y[i][COORD_BITS-1:0]);
        // Now and then a query lands in the middle of building a polygon.
        if ($urandom_range(19) == 0)
          send_beat(OP_QUERY, 1'($urandom_range(1)), pick_coord(style, center_x),
                    pick_coord(style, center_y));
      end

      q = $urandom_range(6, 1);
      for (int k = 0; k < q; k++) begin
        mode = (n == 0) ? 0 : $urandom_range(4);
        a = (n == 0) ? 0 : $urandom_range(n - 1);
        b = (n == 0) ? 0 : $urandom_range(n - 1);
        case (mode)
          0: send_beat(OP_QUERY, 1'($urandom_range(1)), pick_coord(style, center_x),
                       pick_coord(style, center_y));
          1: send_beat(OP_QUERY, 1'($urandom_range(1)), shape_x[a][COORD_BITS-1:0],
                       shape_y[a][COORD_BITS-1:0]);
          2: send_beat(OP_QUERY, 1'($urandom_range(1)), pick_coord(style, center_x),
                       shape_y[a][COORD_BITS-1:0]);
          3: send_beat(OP_QUERY, 1'($urandom_range(1)),
                       clamp_coord(shape_x[a] + int'($urandom_range(2)) - 1),
                       clamp_coord((shape_y[a] + shape_y[b]) / 2));
          default: send_beat(OP_QUERY, 1'($urandom_range(1)),
                             clamp_coord((shape_x[a] + shape_x[b]) / 2),
                             clamp_coord((shape_y[a] + shape_y[b]) / 2));
        endcase
      end

      if ($urandom_range(19) == 0) wait_drained();
    end

    calm = 1'b0;
    wait_drained();
    repeat (100) @(posedge clk);

    $display("Covered %0d vertex appends (%0d dropped on a full store) and %0d queries.",
             sent_appends, drop_count, sent_queries);
    $display("%0d of the queries were answered inside the polygon.", inside_count);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/pip_pkg.sv
src/pip_front.sv
src/pip_queue.sv
src/pip_back.sv
src/point_in_polygon_test.sv
tb/pip_checker.sv
tb/point_in_polygon_test_tb.sv
